// File: design/vdw_pkg.sv
// Shared constants, types and helpers of the variant density window detector.
`timescale 1ns / 1ps

package vdw_pkg;

   // Window queue geometry
   localparam int QUEUE_DEPTH = 1024;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int CONTIG_W   = 16;
   localparam int POS_W      = 31;
   localparam int REGION_W   = 32;
   localparam int THRESH_W   = 10;
   localparam int CMP_W      = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 32;

   // Register map
   localparam logic [CSR_ADDR_W-1:0] CSR_COUNT_THRESHOLD = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_SPAN     = CSR_ADDR_W'(1);

   // Register reset values
   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(10);
   localparam logic [POS_W-1:0]    SPAN_RESET   = POS_W'(100);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_SWITCH
   } vdw_state_type;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
      next_slot = (slot == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : slot + PTR_W'(1);
   endfunction

endpackage

// File: design/vdw_if.sv
// Channel interfaces: variant word in, region word out, register write word.
`timescale 1ns / 1ps

interface vdw_req_if;
   logic                          valid;
   logic                          ready;
   logic [vdw_pkg::CONTIG_W-1:0]  contig_id;
   logic [vdw_pkg::POS_W-1:0]     position;

   modport source (output valid, contig_id, position, input ready);
   modport sink   (input valid, contig_id, position, output ready);
endinterface

interface vdw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vdw_pkg::CONTIG_W-1:0]  region_contig;
   logic [vdw_pkg::REGION_W-1:0]  region_start;
   logic [vdw_pkg::REGION_W-1:0]  region_end;

   modport source (output valid, region_contig, region_start, region_end, input ready);
   modport sink   (input valid, region_contig, region_start, region_end, output ready);
endinterface

interface vdw_csr_if;
   logic                            valid;
   logic                            ready;
   logic [vdw_pkg::CSR_ADDR_W-1:0]  index;
   logic [vdw_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/vdw_ram.sv
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module vdw_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/variant_density_window_detector.sv
// Top level: sliding-window variant density detector with a RAM-backed position queue.
`timescale 1ns / 1ps

//  channel   | dir | handshake    | word
//  ----------+-----+--------------+-----------------------------------------------
//  req_chan  | in  | valid/ready  | contig_id[15:0], position[30:0]
//  rsp_chan  | out | valid/ready  | region_contig[15:0], region_start/end[31:0]
//  csr_chan  | in  | valid/ready  | index[7:0] (0 threshold, 1 span), data[31:0]
//
//  Steps: the first word after reset is only stored; a word on a new contig goes to
//  SWITCH; any other word goes to SCAN, which drops head entries out of the window
//  by a RAM read in LOAD and a compare in SCAN; a full queue evicts its head via LOAD.
//  The window positions live in one RAM with a registered read.
//  Reset is synchronous; the RAM needs no clearing pass, the fill count guards it.
//  A waiting region word holds the sequencer only when another region must go out;
//  a new variant word is taken while a result still waits in the output register.

module variant_density_window_detector (
   input  logic     clock,
   input  logic     reset,
   vdw_req_if.sink  req_chan,
   vdw_rsp_if.source rsp_chan,
   vdw_csr_if.sink  csr_chan
);

   // Configuration registers
   logic [vdw_pkg::THRESH_W-1:0]  thresh_ff, thresh_in;
   logic [vdw_pkg::POS_W-1:0]     span_ff, span_in;

   // Sequencer and window state
   vdw_pkg::vdw_state_type        state_ff, state_in;
   logic [vdw_pkg::PTR_W-1:0]     head_ff, head_in;
   logic [vdw_pkg::PTR_W-1:0]     tail_ff, tail_in;
   logic [vdw_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [vdw_pkg::CONTIG_W-1:0]  contig_ff, contig_in;
   logic                          pending_ff, pending_in;
   logic [vdw_pkg::POS_W-1:0]     dstart_ff, dstart_in;
   logic [vdw_pkg::POS_W-1:0]     dend_ff, dend_in;

   // Cached copy of the RAM entry at the head, and the word in flight
   logic [vdw_pkg::POS_W-1:0]     head_pos_ff, head_pos_in;
   logic [vdw_pkg::POS_W-1:0]     item_pos_ff, item_pos_in;
   logic [vdw_pkg::CONTIG_W-1:0]  item_contig_ff, item_contig_in;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [vdw_pkg::CONTIG_W-1:0]  rsp_contig_ff, rsp_contig_in;
   logic [vdw_pkg::REGION_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [vdw_pkg::REGION_W-1:0]  rsp_end_ff, rsp_end_in;

   // RAM ports
   logic                          ram_wr_en;
   logic [vdw_pkg::PTR_W-1:0]     ram_wr_addr;
   logic                          ram_rd_en;
   logic [vdw_pkg::PTR_W-1:0]     ram_rd_addr;
   logic [vdw_pkg::POS_W-1:0]     ram_rd_data;

   // Control terms
   logic                          req_fire;
   logic                          queue_empty;
   logic                          queue_full;
   logic                          contig_change;
   logic                          slot_busy;
   logic                          stall;
   logic                          too_far;
   logic                          over_thresh;
   logic                          emit;
   logic signed [vdw_pkg::REGION_W-1:0] head_gap;

   vdw_ram #(
      .DEPTH (vdw_pkg::QUEUE_DEPTH),
      .WIDTH (vdw_pkg::POS_W)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_chan.position),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Shared terms
   // ---------------------------------------------------------------------
   assign req_fire      = req_chan.valid && req_chan.ready;
   assign queue_empty   = (count_ff == '0);
   assign queue_full    = (count_ff == vdw_pkg::CNT_W'(vdw_pkg::QUEUE_DEPTH));
   assign contig_change = (req_chan.contig_id != contig_ff);

   // The output register is busy when its word is not taken this cycle.
   assign slot_busy = rsp_valid_ff && !rsp_chan.ready;
   // Hold only when a pending region has to go out and the slot is busy.
   assign stall     = pending_ff && slot_busy;

   // Signed distance from the head entry to the newest entry.
   assign head_gap = $signed({1'b0, item_pos_ff}) - $signed({1'b0, head_pos_ff});
   assign too_far  = head_gap > $signed({1'b0, span_ff});

   assign over_thresh = vdw_pkg::CMP_W'(count_ff) > vdw_pkg::CMP_W'(thresh_ff);

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vdw_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (queue_empty) begin
                  state_in = vdw_pkg::ST_IDLE;
               end else if (contig_change) begin
                  state_in = vdw_pkg::ST_SWITCH;
               end else if (queue_full) begin
                  state_in = vdw_pkg::ST_LOAD;
               end else begin
                  state_in = vdw_pkg::ST_SCAN;
               end
            end
         end
         vdw_pkg::ST_LOAD: begin
            state_in = vdw_pkg::ST_SCAN;
         end
         vdw_pkg::ST_SCAN: begin
            if (too_far) begin
               state_in = stall ? vdw_pkg::ST_SCAN : vdw_pkg::ST_LOAD;
            end else begin
               state_in = vdw_pkg::ST_IDLE;
            end
         end
         vdw_pkg::ST_SWITCH: begin
            state_in = stall ? vdw_pkg::ST_SWITCH : vdw_pkg::ST_IDLE;
         end
         default: begin
            state_in = vdw_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Outputs of the sequencer: handshake, RAM strobes, region emit
   // ---------------------------------------------------------------------
   always_comb begin
      req_chan.ready = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = vdw_pkg::next_slot(head_ff);
      emit           = 1'b0;
      case (state_ff)
         vdw_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_fire) begin
               // Push at the new tail; a full queue also drops its head, so fetch the next one.
               ram_wr_en   = 1'b1;
               ram_wr_addr = queue_empty ? '0 : vdw_pkg::next_slot(tail_ff);
               ram_rd_en   = queue_full;
            end
         end
         vdw_pkg::ST_SCAN: begin
            if (too_far && !stall) begin
               ram_rd_en = 1'b1;
               emit      = pending_ff;
            end
         end
         vdw_pkg::ST_SWITCH: begin
            emit = pending_ff && !stall;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Window datapath
   // ---------------------------------------------------------------------
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      contig_in      = contig_ff;
      pending_in     = pending_ff;
      dstart_in      = dstart_ff;
      dend_in        = dend_ff;
      head_pos_in    = head_pos_ff;
      item_pos_in    = item_pos_ff;
      item_contig_in = item_contig_ff;

      // Emitting a region clears the pending mark, unless a contig switch opens a new one.
      if (emit) begin
         pending_in = 1'b0;
      end

      case (state_ff)
         vdw_pkg::ST_IDLE: begin
            if (req_fire) begin
               item_pos_in    = req_chan.position;
               item_contig_in = req_chan.contig_id;
               if (queue_empty) begin
                  // First word: store it and adopt its contig, no density check.
                  head_in     = '0;
                  tail_in     = '0;
                  count_in    = vdw_pkg::CNT_W'(1);
                  head_pos_in = req_chan.position;
                  contig_in   = req_chan.contig_id;
               end else begin
                  tail_in = vdw_pkg::next_slot(tail_ff);
                  // A full queue evicts its oldest entry, so the count stays put.
                  if (queue_full) begin
                     head_in = vdw_pkg::next_slot(head_ff);
                  end else begin
                     count_in = count_ff + vdw_pkg::CNT_W'(1);
                  end
               end
            end
         end
         vdw_pkg::ST_LOAD: begin
            head_pos_in = ram_rd_data;
         end
         vdw_pkg::ST_SCAN: begin
            if (too_far) begin
               if (!stall) begin
                  head_in  = vdw_pkg::next_slot(head_ff);
                  count_in = count_ff - vdw_pkg::CNT_W'(1);
               end
            end else begin
               if (over_thresh) begin
                  pending_in = 1'b1;
                  dstart_in  = head_pos_ff;
               end
               dend_in = item_pos_ff;
            end
         end
         vdw_pkg::ST_SWITCH: begin
            if (!stall) begin
               // Flush everything but the newest entry and move to the new contig.
               head_in     = tail_ff;
               count_in    = vdw_pkg::CNT_W'(1);
               head_pos_in = item_pos_ff;
               contig_in   = item_contig_ff;
               if (vdw_pkg::CMP_W'(1) > vdw_pkg::CMP_W'(thresh_ff)) begin
                  pending_in = 1'b1;
                  dstart_in  = item_pos_ff;
               end
               dend_in = item_pos_ff;
            end
         end
         default: begin
            head_in = head_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Output register: load on emit, drop when taken
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_contig_in = rsp_contig_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      if (emit) begin
         // Regions go out one-based, tagged with the window's contig.
         rsp_valid_in  = 1'b1;
         rsp_contig_in = contig_ff;
         rsp_start_in  = {1'b0, dstart_ff} + vdw_pkg::REGION_W'(1);
         rsp_end_in    = {1'b0, dend_ff} + vdw_pkg::REGION_W'(1);
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.region_contig = rsp_contig_ff;
   assign rsp_chan.region_start  = rsp_start_ff;
   assign rsp_chan.region_end    = rsp_end_ff;

   // ---------------------------------------------------------------------
   // Configuration writes; unknown indexes are dropped
   // ---------------------------------------------------------------------
   assign csr_chan.ready = 1'b1;

   always_comb begin
      thresh_in = thresh_ff;
      span_in   = span_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            vdw_pkg::CSR_COUNT_THRESHOLD: thresh_in = csr_chan.data[vdw_pkg::THRESH_W-1:0];
            vdw_pkg::CSR_WINDOW_SPAN:     span_in   = csr_chan.data[vdw_pkg::POS_W-1:0];
            default:                      thresh_in = thresh_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= vdw_pkg::THRESH_RESET;
         span_ff      <= vdw_pkg::SPAN_RESET;
         state_ff     <= vdw_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         contig_ff    <= '0;
         pending_ff   <= 1'b0;
         dstart_ff    <= '0;
         dend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         span_ff      <= span_in;
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         contig_ff    <= contig_in;
         pending_ff   <= pending_in;
         dstart_ff    <= dstart_in;
         dend_ff      <= dend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_pos_ff    <= head_pos_in;
      item_pos_ff    <= item_pos_in;
      item_contig_ff <= item_contig_in;
      rsp_contig_ff  <= rsp_contig_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_end_ff     <= rsp_end_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // The queue never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= vdw_pkg::CNT_W'(vdw_pkg::QUEUE_DEPTH))
      else $error("window count beyond queue depth");

   // Work on a word only ever happens with a non-empty window.
   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff != vdw_pkg::ST_IDLE |-> count_ff != '0)
      else $error("sequencer busy on an empty window");

   // A region is never loaded over a word that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> !slot_busy)
      else $error("region word overwritten in output register");

   // A finished contig switch leaves exactly the newest entry.
   a_switch_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vdw_pkg::ST_SWITCH && !stall)
         |=> (count_ff == vdw_pkg::CNT_W'(1) && head_ff == tail_ff))
      else $error("contig switch left more than one entry");

endmodule

// File: sim/tb_variant_density_window_detector.sv
// Self-checking testbench for the variant density window detector: directed and random streams.
`timescale 1ns / 1ps

module tb_variant_density_window_detector;

   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 7;
   // Worst case work left after the last word: a pop per queued entry.
   localparam int SETTLE_CYCLES = 2 * vdw_pkg::QUEUE_DEPTH + 16;
   localparam int STALL_LIMIT   = 20000;
   localparam int RANDOM_REGION_GOAL = 48;
   localparam int MIXED_ROUNDS_MAX   = 3;

   localparam logic [vdw_pkg::POS_W-1:0]      POS_MAX          = '1;
   localparam logic [vdw_pkg::CSR_ADDR_W-1:0] CSR_UNMAPPED_LOW = vdw_pkg::CSR_ADDR_W'(2);
   localparam logic [vdw_pkg::CSR_ADDR_W-1:0] CSR_UNMAPPED_TOP = '1;

   typedef struct packed {
      logic [vdw_pkg::CONTIG_W-1:0] region_contig;
      logic [vdw_pkg::REGION_W-1:0] region_start;
      logic [vdw_pkg::REGION_W-1:0] region_end;
   } region_word_type;

   // Ways the result side throttles its ready.
   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_CADENCE
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vdw_req_if req_if ();
   vdw_rsp_if rsp_if ();
   vdw_csr_if csr_if ();

   variant_density_window_detector i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Window tracker: its own copy of the registers, the position queue and the dense region.
   // ---------------------------------------------------------------------------------------
   logic [vdw_pkg::THRESH_W-1:0] thresh_cfg = vdw_pkg::THRESH_RESET;
   logic [vdw_pkg::POS_W-1:0]    span_cfg   = vdw_pkg::SPAN_RESET;
   logic [vdw_pkg::POS_W-1:0]    win_pos [vdw_pkg::QUEUE_DEPTH];
   int                           win_head   = 0;
   int                           win_tail   = 0;
   int                           win_fill   = 0;
   logic [vdw_pkg::CONTIG_W-1:0] win_contig = '0;
   bit                           dense_open = 1'b0;
   logic [vdw_pkg::POS_W-1:0]    dense_lo   = '0;
   logic [vdw_pkg::POS_W-1:0]    dense_hi   = '0;

   region_word_type region_expect_q [$];
   int              regions_predicted = 0;
   int              fail_count        = 0;

   function automatic void apply_register(input logic [vdw_pkg::CSR_ADDR_W-1:0] idx,
                                          input logic [vdw_pkg::CSR_DATA_W-1:0] data);
      // Unmapped indexes fall through and change nothing.
      if (idx == vdw_pkg::CSR_COUNT_THRESHOLD)
         thresh_cfg = data[vdw_pkg::THRESH_W-1:0];
      else if (idx == vdw_pkg::CSR_WINDOW_SPAN)
         span_cfg = data[vdw_pkg::POS_W-1:0];
   endfunction

   function automatic void drop_oldest();
      if (win_fill > 0) begin
         win_head = (win_head + 1) % vdw_pkg::QUEUE_DEPTH;
         win_fill--;
      end
   endfunction

   // Queue the pending dense region, reported one-based, and close it.
   function automatic bit release_region();
      region_word_type word;
      if (!dense_open)
         return 1'b0;
      word.region_contig = win_contig;
      word.region_start  = {1'b0, dense_lo} + vdw_pkg::REGION_W'(1);
      word.region_end    = {1'b0, dense_hi} + vdw_pkg::REGION_W'(1);
      region_expect_q.push_back(word);
      regions_predicted++;
      dense_open = 1'b0;
      return 1'b1;
   endfunction

   function automatic void predict_variant(input logic [vdw_pkg::CONTIG_W-1:0] contig,
                                           input logic [vdw_pkg::POS_W-1:0]    pos);
      bit     was_empty;
      bit     emitted;
      longint distance;
      was_empty = (win_fill == 0);
      emitted   = 1'b0;

      // A full queue silently loses its oldest position.
      if (win_fill >= vdw_pkg::QUEUE_DEPTH)
         drop_oldest();
      if (win_fill == 0) begin
         win_head = 0;
         win_tail = 0;
      end else begin
         win_tail = (win_tail + 1) % vdw_pkg::QUEUE_DEPTH;
      end
      win_pos[win_tail] = pos;
      win_fill++;

      // The very first word only seeds the window.
      if (was_empty) begin
         win_contig = contig;
         return;
      end

      if (contig != win_contig) begin
         // New contig: report the old region under the old contig, keep only the newest word.
         emitted = release_region();
         while (win_fill > 1)
            drop_oldest();
         win_contig = contig;
      end else begin
         // Trim the head until it lies within the span; the first trim reports the region.
         // A step back gives a negative distance and trims nothing.
         while (1'b1) begin
            distance = longint'(win_pos[win_tail]) - longint'(win_pos[win_head]);
            if (distance <= longint'(span_cfg))
               break;
            if (!emitted)
               emitted = release_region();
            drop_oldest();
         end
      end

      if (win_fill > int'(thresh_cfg)) begin
         dense_open = 1'b1;
         dense_lo   = win_pos[win_head];
         dense_hi   = win_pos[win_tail];
      end else begin
         dense_hi = win_pos[win_tail];
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Variant sender: bursts of random length, random gaps between them.
   // ---------------------------------------------------------------------------------------
   int send_burst_left = 0;

   task automatic send_variant(input logic [vdw_pkg::CONTIG_W-1:0] contig,
                               input logic [vdw_pkg::POS_W-1:0]    pos);
      int gap_cycles;
      if (send_burst_left == 0) begin
         send_burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 96)
                                                        : $urandom_range(1, 12);
         case ($urandom_range(0, 5))
            0, 1: begin
               gap_cycles = 0;
            end
            5: begin
               gap_cycles = $urandom_range(8, 24);
            end
            default: begin
               gap_cycles = $urandom_range(1, 4);
            end
         endcase
         if (gap_cycles > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap_cycles) @(posedge clock);
         end
      end
      req_if.valid     <= 1'b1;
      req_if.contig_id <= contig;
      req_if.position  <= pos;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      send_burst_left--;
      predict_variant(contig, pos);
   endtask

   // Drop valid, end the burst and wait on the clock so the next raise lands in a later step.
   task automatic hold_requests();
      req_if.valid   <= 1'b0;
      send_burst_left = 0;
      @(posedge clock);
   endtask

   task automatic write_register(input logic [vdw_pkg::CSR_ADDR_W-1:0] idx,
                                 input logic [vdw_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      apply_register(idx, data);
      csr_if.valid <= 1'b0;
   endtask

   // Wait for every expected region, then for any trimming still running inside the block.
   task automatic drain_results();
      hold_requests();
      while (region_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [vdw_pkg::CSR_DATA_W-1:0] thresh_word,
                            input logic [vdw_pkg::CSR_DATA_W-1:0] span_word);
      drain_results();
      write_register(vdw_pkg::CSR_COUNT_THRESHOLD, thresh_word);
      write_register(vdw_pkg::CSR_WINDOW_SPAN, span_word);
   endtask

   // ---------------------------------------------------------------------------------------
   // Random variant stream: mostly sorted positions with steps sized so the window count
   // hovers around the threshold; the rest contig changes, steps back and long jumps.
   // ---------------------------------------------------------------------------------------
   logic [vdw_pkg::CONTIG_W-1:0] gen_contig = '0;
   longint                       gen_pos    = 0;

   task automatic run_variant_stream(input int words, input int change_pct, input int noise_pct);
      longint step_max;
      int     roll;
      repeat (words) begin
         step_max = (2 * longint'(span_cfg)) / (longint'(thresh_cfg) + 1) + 1;
         if (step_max > 65536)
            step_max = 65536;
         roll = $urandom_range(0, 99);
         if (roll < change_pct) begin
            gen_contig = $urandom_range(0, 1)
                            ? gen_contig + 1'b1
                            : vdw_pkg::CONTIG_W'($urandom_range(0, 65535));
            gen_pos = ($urandom_range(0, 3) == 0) ? longint'($urandom & POS_MAX)
                                                  : longint'($urandom_range(0, 1000000));
         end else if (roll < change_pct + noise_pct / 3) begin
            // step back: negative head-to-tail distance
            gen_pos -= $urandom_range(1, 300);
         end else if (roll < change_pct + noise_pct) begin
            // jump past the window to trim several head entries at once
            gen_pos += 2 * longint'(span_cfg) + $urandom_range(0, 1000);
         end else begin
            gen_pos += $urandom_range(0, int'(step_max));
         end
         if (gen_pos < 0)
            gen_pos = 0;
         if (gen_pos > longint'(POS_MAX))
            gen_pos = POS_MAX;
         send_variant(gen_contig, vdw_pkg::POS_W'(gen_pos));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Reset values in force: threshold 10, span 100.
   task automatic test_reset_defaults();
      // first word seeds the window; twelve words 5 apart pass the threshold
      for (int i = 0; i < 12; i++)
         send_variant(16'h0001, vdw_pkg::POS_W'(5 * i));
      // a new contig closes the dense region
      send_variant(16'h0002, vdw_pkg::POS_W'(7));
   endtask

   // Threshold zero makes one entry dense; span one trims on nearly every step.
   task automatic test_zero_threshold();
      // high data bits must be masked off: threshold 0, span 1
      configure(32'hFFFF_FC00, 32'h8000_0001);
      send_variant(16'hFFFF, vdw_pkg::POS_W'(0));
      send_variant(16'hFFFF, vdw_pkg::POS_W'(1));
      send_variant(16'hFFFF, vdw_pkg::POS_W'(3));
      send_variant(16'hFFFF, vdw_pkg::POS_W'(2));
      // extreme positions and contigs; each change reports the old contig's region
      send_variant(16'h0000, POS_MAX);
      send_variant(16'h5555, 31'h2AAA_AAAA);
      send_variant(16'hAAAA, 31'h5555_5555);
   endtask

   // Unmapped indexes are ignored; then the register extremes.
   task automatic test_register_map();
      drain_results();
      write_register(CSR_UNMAPPED_LOW, 32'hFFFF_FFFF);
      write_register(CSR_UNMAPPED_TOP, 32'h7FFF_FFFF);
      // still threshold 0 and span 1: the first of these trims and reports
      send_variant(16'hAAAA, 31'h5555_5557);
      send_variant(16'hAAAA, 31'h5555_5558);
      configure(32'h0000_03FF, 32'h7FFF_FFFF);
      send_variant(16'h0F0F, vdw_pkg::POS_W'(100));
      send_variant(16'h0F0F, POS_MAX);
      send_variant(16'hF0F0, vdw_pkg::POS_W'(5));
   endtask

   task automatic test_random_default_window();
      configure(32'd10, 32'd100);
      run_variant_stream(100, 3, 8);
   endtask

   task automatic test_random_narrow_window();
      configure(32'd0, 32'd1);
      run_variant_stream(60, 3, 8);
   endtask

   // Overfill the queue on one contig so the oldest positions get evicted.
   task automatic test_full_queue_eviction();
      configure(32'd1023, 32'h7FFF_FFFF);
      gen_pos = $urandom_range(0, 1 << 20);
      run_variant_stream(vdw_pkg::QUEUE_DEPTH + 16, 0, 0);
      // change contig to report the region built up meanwhile
      run_variant_stream(1, 100, 0);
   endtask

   // Random settings; add a few rounds while too few regions came out of the random part.
   task automatic test_random_mixed(input int region_mark);
      int rounds;
      rounds = 0;
      configure(32'd3, 32'd50);
      run_variant_stream(70, 3, 8);
      configure($urandom_range(1, 40), $urandom_range(1, 5000));
      run_variant_stream(70, 3, 8);
      while (regions_predicted - region_mark < RANDOM_REGION_GOAL &&
             rounds < MIXED_ROUNDS_MAX) begin
         configure($urandom_range(0, 20), $urandom_range(1, 2000));
         run_variant_stream(40, 3, 8);
         rounds++;
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side: ready stalls on its own pattern, changing mode every so often.
   // ---------------------------------------------------------------------------------------
   rx_mode_type rsp_mode      = RX_OPEN;
   int          rsp_mode_left = 0;
   int          rsp_tick      = 0;

   always @(posedge clock) begin
      if (rsp_mode_left == 0) begin
         rsp_mode      = rx_mode_type'($urandom_range(0, 3));
         rsp_mode_left = $urandom_range(16, 160);
      end else begin
         rsp_mode_left--;
      end
      rsp_tick++;
      case (rsp_mode)
         RX_OPEN: begin
            rsp_if.ready <= 1'b1;
         end
         RX_COIN: begin
            rsp_if.ready <= 1'($urandom_range(0, 1));
         end
         RX_SPARSE: begin
            rsp_if.ready <= ($urandom_range(0, 7) == 0);
         end
         default: begin
            rsp_if.ready <= (rsp_tick % 5) != 0;
         end
      endcase
   end

   // Compare each accepted region word with the oldest expectation.
   always @(posedge clock) begin
      region_word_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (region_expect_q.size() == 0) begin
            $error("region word with none expected: contig %0h start %0d end %0d",
                   rsp_if.region_contig, rsp_if.region_start, rsp_if.region_end);
            fail_count++;
         end else begin
            want = region_expect_q.pop_front();
            if (rsp_if.region_contig !== want.region_contig) begin
               $error("region_contig: expected %0h, got %0h",
                      want.region_contig, rsp_if.region_contig);
               fail_count++;
            end
            if (rsp_if.region_start !== want.region_start) begin
               $error("region_start: expected %0d, got %0d",
                      want.region_start, rsp_if.region_start);
               fail_count++;
            end
            if (rsp_if.region_end !== want.region_end) begin
               $error("region_end: expected %0d, got %0d", want.region_end, rsp_if.region_end);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no word moves on any channel for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (csr_if.valid === 1'b1 && csr_if.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_variant_density_window_detector NOT OK");
         $finish;
      end
   end

   initial begin
      int region_mark;
      req_if.valid     <= 1'b0;
      req_if.contig_id <= '0;
      req_if.position  <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= '0;
      csr_if.data      <= '0;

      // hold reset, then release it on an edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_threshold();
      test_register_map();

      region_mark = regions_predicted;
      test_random_default_window();
      test_random_narrow_window();
      test_full_queue_eviction();
      test_random_mixed(region_mark);

      drain_results();
      if (fail_count == 0) begin
         $display("tb_variant_density_window_detector OK");
      end else begin
         $display("tb_variant_density_window_detector NOT OK");
      end
      $finish;
   end

endmodule

// File: sim.f
design/vdw_pkg.sv
design/vdw_if.sv
design/vdw_ram.sv
design/variant_density_window_detector.sv
sim/tb_variant_density_window_detector.sv
